// ----- hdl/pmb_pkg.sv -----
// ----------------------------------------------------------------------------
// pmb_pkg : shared types and constants for the peak meter ballistics core
// Register indexes, reset values and the fixed-width configuration bundle.
// ----------------------------------------------------------------------------
package pmb_pkg;

    // default level width, signed Q8.8 dB
    localparam int LEVEL_WIDTH_DEF = 16;

    // fixed register widths
    localparam int COEFF_W = 16;
    localparam int TICKS_W = 10;
    localparam int STEP_W  = 12;
    localparam int CFG_IDX_W = 3;

    // hold tick counter saturates here
    localparam logic [TICKS_W-1:0] CNT_MAX = {TICKS_W{1'b1}};

    // register reset values
    localparam int                 RST_FLOOR_DB   = -15360;
    localparam int                 RST_CEILING_DB = 0;
    localparam logic [COEFF_W-1:0] RST_ATTACK     = 16'd32768;
    localparam logic [COEFF_W-1:0] RST_RELEASE    = 16'd5243;
    localparam logic [TICKS_W-1:0] RST_HOLD_TICKS = 10'd18;
    localparam logic [STEP_W-1:0]  RST_FALL_STEP  = 12'd171;
    localparam logic               RST_HOLD_EN    = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOOR_DB       = 3'd0,
        CFG_CEILING_DB     = 3'd1,
        CFG_ATTACK_COEFF   = 3'd2,
        CFG_RELEASE_COEFF  = 3'd3,
        CFG_HOLD_TICKS     = 3'd4,
        CFG_HOLD_FALL_STEP = 3'd5,
        CFG_HOLD_ENABLE    = 3'd6
    } t_cfg_idx;

    // ballistics settings that do not scale with the level width
    typedef struct packed {
        logic [COEFF_W-1:0] attack_coeff;
        logic [COEFF_W-1:0] release_coeff;
        logic [TICKS_W-1:0] hold_ticks;
        logic [STEP_W-1:0]  hold_fall_step;
        logic               hold_enable;
    } t_ballistics_cfg;

endpackage

// ----- hdl/pmb_update.sv -----
// ----------------------------------------------------------------------------
// pmb_update : one meter tick of smoothing and peak hold
// Clamps the new level, runs the attack/release one-pole filter and updates
// the held peak and its tick counter; also forms the clamped meter outputs.
// ----------------------------------------------------------------------------
module pmb_update
    import pmb_pkg::*;
#(
    parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
    input  logic signed [LEVEL_WIDTH-1:0] i_level,
    input  logic signed [LEVEL_WIDTH-1:0] i_smooth,
    input  logic signed [LEVEL_WIDTH-1:0] i_held,
    input  logic        [TICKS_W-1:0]     i_cnt,
    input  logic signed [LEVEL_WIDTH-1:0] i_floor,
    input  logic signed [LEVEL_WIDTH-1:0] i_ceiling,
    input  t_ballistics_cfg               i_cfg,
    output logic signed [LEVEL_WIDTH-1:0] o_smooth,
    output logic signed [LEVEL_WIDTH-1:0] o_held,
    output logic        [TICKS_W-1:0]     o_cnt,
    output logic signed [LEVEL_WIDTH-1:0] o_bar_level,
    output logic signed [LEVEL_WIDTH-1:0] o_hold_level
);

    localparam int DIFF_W = LEVEL_WIDTH + 1;
    localparam int PROD_W = LEVEL_WIDTH + COEFF_W + 1;

    logic signed [LEVEL_WIDTH-1:0] level_c;
    logic signed [DIFF_W-1:0]      diff;
    logic        [COEFF_W-1:0]     coeff;
    logic signed [PROD_W-1:0]      prod;
    logic signed [DIFF_W-1:0]      delta;
    logic signed [DIFF_W-1:0]      smooth_sum;
    logic signed [DIFF_W-1:0]      dropped;
    logic        [TICKS_W-1:0]     cnt_inc;

    // when floor and ceiling are crossed, levels below the floor take the floor and all others the ceiling
    function automatic logic signed [LEVEL_WIDTH-1:0] clamp_lvl(
        input logic signed [LEVEL_WIDTH-1:0] v,
        input logic signed [LEVEL_WIDTH-1:0] lo,
        input logic signed [LEVEL_WIDTH-1:0] hi
    );
        logic signed [LEVEL_WIDTH-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (hi < v) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // clamp input and pick attack or release by direction
    always_comb begin
        level_c = clamp_lvl(i_level, i_floor, i_ceiling);
        diff    = DIFF_W'(level_c) - DIFF_W'(i_smooth);
        coeff   = (level_c > i_smooth) ? i_cfg.attack_coeff : i_cfg.release_coeff;
    end

    // one-pole step; the arithmetic shift floors towards minus infinity
    always_comb begin
        prod       = PROD_W'(diff) * $signed({{(PROD_W-COEFF_W){1'b0}}, coeff});
        delta      = prod[PROD_W-1:COEFF_W];
        smooth_sum = DIFF_W'(i_smooth) + delta;
        o_smooth   = smooth_sum[LEVEL_WIDTH-1:0];
    end

    // peak capture, hold count and decay of the held peak
    always_comb begin
        cnt_inc = (i_cnt != CNT_MAX) ? i_cnt + 1'b1 : i_cnt;
        dropped = DIFF_W'(i_held) - $signed({{(DIFF_W-STEP_W){1'b0}}, i_cfg.hold_fall_step});
        o_held  = i_held;
        o_cnt   = i_cnt;
        if (i_cfg.hold_enable) begin
            if (o_smooth > i_held) begin
                o_held = o_smooth;
                o_cnt  = '0;
            end else begin
                o_cnt = cnt_inc;
                if (cnt_inc >= i_cfg.hold_ticks) begin
                    o_held = (dropped > DIFF_W'(o_smooth)) ? dropped[LEVEL_WIDTH-1:0]
                                                           : o_smooth;
                end
            end
        end
    end

    // meter outputs
    always_comb begin
        o_bar_level  = clamp_lvl(o_smooth, i_floor, i_ceiling);
        o_hold_level = i_cfg.hold_enable ? clamp_lvl(o_held, i_floor, i_ceiling) : i_floor;
    end

endmodule

// ----- hdl/peak_meter_ballistics_core.sv -----
// ----------------------------------------------------------------------------
// peak_meter_ballistics_core : attack/release level meter with peak hold
// Smooths a stream of dB levels and tracks a decaying held peak.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one request per meter tick, tdata carries level_db (signed
//   Q8.8). Master stream: one request per tick with bar_level and hold_level.
//   Settings are written through i_cfg_we / i_cfg_index / i_cfg_data while
//   no tick is in flight; indexes beyond the register list are ignored.
// Pipeline and throughput
//   A tick is captured in the input register; its result is then written to
//   the output register, which drives m_axis_tvalid, and a master stall can
//   hold the tick in between. One tick is taken every cycle unless the master
//   stalls; smoothing and hold state loop through one multiply-add per cycle.
// Reset
//   Synchronous, active low: pipeline emptied, settings back to defaults,
//   smoothed level and held peak set to the default floor, counter cleared.
// Stall
//   While the master side holds off, the result stays put and the input
//   register keeps one further tick; s_axis_tready drops once both are full.
// ----------------------------------------------------------------------------
module peak_meter_ballistics_core
    import pmb_pkg::*;
#(
    parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_index,
    input  logic [((LEVEL_WIDTH > COEFF_W) ? LEVEL_WIDTH : COEFF_W)-1:0] i_cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((LEVEL_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // level_db
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((2*LEVEL_WIDTH+7)/8)*8-1:0]    m_axis_tdata   // bar_level, hold_level
);

    localparam int OUT_W = ((2 * LEVEL_WIDTH + 7) / 8) * 8;

    localparam logic signed [LEVEL_WIDTH-1:0] FLOOR_RST   = LEVEL_WIDTH'(RST_FLOOR_DB);
    localparam logic signed [LEVEL_WIDTH-1:0] CEILING_RST = LEVEL_WIDTH'(RST_CEILING_DB);

    // settings
    logic signed [LEVEL_WIDTH-1:0] r_floor;
    logic signed [LEVEL_WIDTH-1:0] r_ceiling;
    t_ballistics_cfg               r_cfg;

    // pipeline
    logic                          r_in_valid;
    logic signed [LEVEL_WIDTH-1:0] r_level;
    logic                          r_out_valid;
    logic signed [LEVEL_WIDTH-1:0] r_bar;
    logic signed [LEVEL_WIDTH-1:0] r_hold;

    // meter state
    logic signed [LEVEL_WIDTH-1:0] r_smooth;
    logic signed [LEVEL_WIDTH-1:0] r_held;
    logic        [TICKS_W-1:0]     r_cnt;

    logic                          out_free;
    logic                          advance;
    logic                          in_accept;
    logic signed [LEVEL_WIDTH-1:0] n_smooth;
    logic signed [LEVEL_WIDTH-1:0] n_held;
    logic        [TICKS_W-1:0]     n_cnt;
    logic signed [LEVEL_WIDTH-1:0] n_bar;
    logic signed [LEVEL_WIDTH-1:0] n_hold;

    // handshake: advance when the output register is empty or being drained
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-2*LEVEL_WIDTH){1'b0}}, r_hold, r_bar};

    // tick datapath
    pmb_update #(
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_update (
        .i_level      (r_level),
        .i_smooth     (r_smooth),
        .i_held       (r_held),
        .i_cnt        (r_cnt),
        .i_floor      (r_floor),
        .i_ceiling    (r_ceiling),
        .i_cfg        (r_cfg),
        .o_smooth     (n_smooth),
        .o_held       (n_held),
        .o_cnt        (n_cnt),
        .o_bar_level  (n_bar),
        .o_hold_level (n_hold)
    );

    // write settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor              <= FLOOR_RST;
            r_ceiling            <= CEILING_RST;
            r_cfg.attack_coeff   <= RST_ATTACK;
            r_cfg.release_coeff  <= RST_RELEASE;
            r_cfg.hold_ticks     <= RST_HOLD_TICKS;
            r_cfg.hold_fall_step <= RST_FALL_STEP;
            r_cfg.hold_enable    <= RST_HOLD_EN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FLOOR_DB:       r_floor              <= i_cfg_data[LEVEL_WIDTH-1:0];
                CFG_CEILING_DB:     r_ceiling            <= i_cfg_data[LEVEL_WIDTH-1:0];
                CFG_ATTACK_COEFF:   r_cfg.attack_coeff   <= i_cfg_data[COEFF_W-1:0];
                CFG_RELEASE_COEFF:  r_cfg.release_coeff  <= i_cfg_data[COEFF_W-1:0];
                CFG_HOLD_TICKS:     r_cfg.hold_ticks     <= i_cfg_data[TICKS_W-1:0];
                CFG_HOLD_FALL_STEP: r_cfg.hold_fall_step <= i_cfg_data[STEP_W-1:0];
                CFG_HOLD_ENABLE:    r_cfg.hold_enable    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline valid flags and meter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_smooth    <= FLOOR_RST;
            r_held      <= FLOOR_RST;
            r_cnt       <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_smooth    <= n_smooth;
                r_held      <= n_held;
                r_cnt       <= n_cnt;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_level <= s_axis_tdata[LEVEL_WIDTH-1:0];
        end
        if (advance) begin
            r_bar  <= n_bar;
            r_hold <= n_hold;
        end
    end

    // state holds while a result waits on the master side
    a_state_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && r_in_valid)
            |=> ($stable(r_smooth) && $stable(r_held) && $stable(r_cnt)))
        else $error("meter state moved while output stalled");

    // an accepted request always lands in the input register
    a_accept_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_in_valid)
        else $error("accepted request lost");

    // a result only appears after a tick sat in the input register
    a_result_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_in_valid))
        else $error("result without a tick");

    // a new peak captured on advance clears the hold counter
    a_capture_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_cfg.hold_enable && (n_smooth > r_held)) |=> (r_cnt == '0))
        else $error("hold counter not cleared on new peak");

endmodule

// ----- sim/peak_meter_ballistics_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peak_meter_ballistics_checker : result checker for the peak meter core
// Follows the settings written to the core and keeps its own smoothed level,
// held peak and hold counter. Each accepted tick yields the bar and hold
// levels it should produce. Each accepted result is compared with the oldest
// of these, field by field.
// ----------------------------------------------------------------------------
module peak_meter_ballistics_checker
    import pmb_pkg::*;
#(
    parameter int LW = LEVEL_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port, as seen by the core
    input  logic                               i_cfg_we,
    input  logic [CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [((LW > COEFF_W) ? LW : COEFF_W)-1:0] i_cfg_data,
    // tick stream
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [((LW+7)/8)*8-1:0]            s_axis_tdata,  // level_db
    // result stream
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [((2*LW+7)/8)*8-1:0]          m_axis_tdata,  // bar_level, hold_level
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_result_count
);

    typedef logic signed [LW-1:0] t_level;

    // one result request: bar level in the low half
    typedef struct packed {
        t_level hold_level;
        t_level bar_level;
    } t_meter_out;

    // settings as last written
    t_level             floor_r;
    t_level             ceil_r;
    logic [COEFF_W-1:0] attack_r;
    logic [COEFF_W-1:0] release_r;
    logic [TICKS_W-1:0] ticks_r;
    logic [STEP_W-1:0]  step_r;
    logic               en_r;

    // meter state
    t_level             smooth_r;
    t_level             peak_r;
    logic [TICKS_W-1:0] count_r;

    t_meter_out meter_q[$];
    int         fail_total;
    int         result_total;

    // When the two cross, levels below the floor take the floor, all others the ceiling
    function automatic t_level clamp_to_meter(input longint v);
        if (v < longint'(floor_r)) return floor_r;
        if (longint'(ceil_r) < v) return ceil_r;
        return t_level'(v);
    endfunction

    // Advance the meter by one tick and return the levels it shows
    function automatic t_meter_out advance_meter(input t_level lvl);
        longint     lvl_c;
        longint     diff;
        longint     coeff;
        longint     dropped;
        t_meter_out r;
        lvl_c = clamp_to_meter(longint'(lvl));
        diff  = lvl_c - longint'(smooth_r);
        if (lvl_c > longint'(smooth_r)) coeff = longint'(attack_r);
        else coeff = longint'(release_r);
        // arithmetic shift floors towards minus infinity
        smooth_r = t_level'(longint'(smooth_r) + ((coeff * diff) >>> 16));

        if (en_r) begin
            if (smooth_r > peak_r) begin
                peak_r  = smooth_r;
                count_r = '0;
            end else begin
                if (count_r != CNT_MAX) count_r = count_r + 1'b1;
                if (count_r >= ticks_r) begin
                    dropped = longint'(peak_r) - longint'(step_r);
                    if (dropped > longint'(smooth_r)) peak_r = t_level'(dropped);
                    else peak_r = smooth_r;
                end
            end
            r.hold_level = clamp_to_meter(longint'(peak_r));
        end else begin
            r.hold_level = floor_r;
        end
        r.bar_level = clamp_to_meter(longint'(smooth_r));
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_meter_out got;
        t_meter_out want;
        if (!i_rst_n) begin
            floor_r   = t_level'(RST_FLOOR_DB);
            ceil_r    = t_level'(RST_CEILING_DB);
            attack_r  = RST_ATTACK;
            release_r = RST_RELEASE;
            ticks_r   = RST_HOLD_TICKS;
            step_r    = RST_FALL_STEP;
            en_r      = RST_HOLD_EN;
            smooth_r  = t_level'(RST_FLOOR_DB);
            peak_r    = t_level'(RST_FLOOR_DB);
            count_r   = '0;
            meter_q.delete();
            fail_total   = 0;
            result_total = 0;
        end else begin
            // compare a delivered result before queueing this edge's tick
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[2*LW-1:0];
                if (meter_q.size() == 0) begin
                    $error("unexpected result: bar_level %0d hold_level %0d",
                           $signed(got.bar_level), $signed(got.hold_level));
                    fail_total++;
                end else begin
                    want = meter_q.pop_front();
                    result_total++;
                    if (got.bar_level !== want.bar_level) begin
                        $error("bar_level mismatch: expected %0d, actual %0d",
                               $signed(want.bar_level), $signed(got.bar_level));
                        fail_total++;
                    end
                    if (got.hold_level !== want.hold_level) begin
                        $error("hold_level mismatch: expected %0d, actual %0d",
                               $signed(want.hold_level), $signed(got.hold_level));
                        fail_total++;
                    end
                end
            end

            // track register writes; bits above each width are dropped
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FLOOR_DB:       floor_r   = i_cfg_data[LW-1:0];
                    CFG_CEILING_DB:     ceil_r    = i_cfg_data[LW-1:0];
                    CFG_ATTACK_COEFF:   attack_r  = i_cfg_data[COEFF_W-1:0];
                    CFG_RELEASE_COEFF:  release_r = i_cfg_data[COEFF_W-1:0];
                    CFG_HOLD_TICKS:     ticks_r   = i_cfg_data[TICKS_W-1:0];
                    CFG_HOLD_FALL_STEP: step_r    = i_cfg_data[STEP_W-1:0];
                    CFG_HOLD_ENABLE:    en_r      = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                meter_q.push_back(advance_meter(s_axis_tdata[LW-1:0]));
        end
        o_pending      <= meter_q.size();
        o_fail_count   <= fail_total;
        o_result_count <= result_total;
    end

endmodule

// ----- sim/peak_meter_ballistics_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peak_meter_ballistics_core_tb : testbench for the peak meter ballistics core
// Drives meter ticks through short directed runs, a long hold-counter run
// and several randomly configured phases of peak-and-decay material, with
// random idling on both streams. The checker beside the core predicts and
// compares every result.
// ----------------------------------------------------------------------------
module peak_meter_ballistics_core_tb;
    import pmb_pkg::*;

    localparam int LW            = LEVEL_WIDTH_DEF;
    localparam int CFG_W         = (LW > COEFF_W) ? LW : COEFF_W;
    localparam int GAP_MAX       = 14;
    localparam int LONG_HOLD_OFF = 64;
    localparam int DRAIN_CYCLES  = 8;
    localparam int SAT_TICKS     = 1045;
    localparam int RAND_PHASES   = 5;
    localparam int RAND_TICKS    = 50;
    localparam int TAIL_TICKS    = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
    localparam longint LEVEL_MIN = -(longint'(1) << (LW - 1));
    localparam longint LEVEL_MAX = (longint'(1) << (LW - 1)) - 1;

    typedef logic signed [LW-1:0] t_level;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index   = '0;
    logic [CFG_W-1:0]            i_cfg_data    = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [((LW+7)/8)*8-1:0]     s_axis_tdata  = '0;  // level_db
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [((2*LW+7)/8)*8-1:0]   m_axis_tdata;        // bar_level, hold_level

    int     fail_count;
    int     pending;
    int     result_count;
    int     ticks_sent      = 0;
    int     settings_loaded = 0;
    bit     quiet_tail      = 1'b0;
    bit     long_hold_req   = 1'b0;
    t_level cur_floor       = t_level'(RST_FLOOR_DB);
    t_level cur_ceil        = t_level'(RST_CEILING_DB);
    longint env_level       = RST_FLOOR_DB;

    always #1 i_clk = ~i_clk;

    peak_meter_ballistics_core #(
        .LEVEL_WIDTH (LW)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    peak_meter_ballistics_checker #(
        .LW (LW)
    ) u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Fill the bits above a narrow register with noise
    function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] v, input int w);
        logic [CFG_W-1:0] mask;
        mask = (CFG_W'(1) << w) - 1'b1;
        return (CFG_W'($urandom) & ~mask) | (v & mask);
    endfunction

    // Pick the next level: mostly peaks with decay, some noise and extremes
    function automatic t_level next_level();
        longint lo;
        longint hi;
        longint v;
        lo = cur_floor;
        hi = cur_ceil;
        if (lo > hi) begin
            v  = lo;
            lo = hi;
            hi = v;
        end
        case ($urandom_range(0, 9))
            0: return t_level'($urandom);
            1: begin
                case ($urandom_range(0, 5))
                    0: return t_level'(LEVEL_MIN);
                    1: return t_level'(LEVEL_MAX);
                    2: return cur_floor;
                    3: return cur_ceil;
                    4: return t_level'(longint'(cur_floor) - 1);
                    default: return t_level'(longint'(cur_ceil) + 1);
                endcase
            end
            default: begin
                if ($urandom_range(0, 11) == 0)
                    env_level = lo + longint'($urandom_range(0, int'(hi - lo)));
                else
                    env_level = env_level - longint'($urandom_range(0, 600));
                if (env_level < lo) env_level = lo;
                return t_level'(env_level + longint'($urandom_range(0, 200)) - 100);
            end
        endcase
    endfunction

    // Offer one tick and hold it until the request is taken
    task automatic send_tick(input t_level lvl);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= lvl;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ticks_sent++;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_meter();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Write every register, plus the unused slot, while the core is idle
    task automatic load_settings(input t_level fl, input t_level ce,
                                 input logic [COEFF_W-1:0] att,
                                 input logic [COEFF_W-1:0] rel,
                                 input logic [TICKS_W-1:0] ticks,
                                 input logic [STEP_W-1:0] step, input logic en);
        write_reg(CFG_FLOOR_DB, fl);
        write_reg(CFG_CEILING_DB, ce);
        write_reg(CFG_ATTACK_COEFF, att);
        write_reg(CFG_RELEASE_COEFF, rel);
        write_reg(CFG_HOLD_TICKS, with_junk(CFG_W'(ticks), TICKS_W));
        write_reg(CFG_HOLD_FALL_STEP, with_junk(CFG_W'(step), STEP_W));
        write_reg(CFG_HOLD_ENABLE, with_junk(CFG_W'(en), 1));
        write_reg(CFG_SPARE_IDX, CFG_W'($urandom));
        i_cfg_we  <= 1'b0;
        cur_floor = fl;
        cur_ceil  = ce;
        env_level = fl;
        settings_loaded++;
        @(posedge i_clk);
    endtask

    task automatic load_random_settings();
        t_level             fl;
        t_level             ce;
        logic [COEFF_W-1:0] att;
        logic [COEFF_W-1:0] rel;
        logic [TICKS_W-1:0] ticks;
        logic [STEP_W-1:0]  step;
        case ($urandom_range(0, 2))
            0: fl = t_level'(LEVEL_MIN);
            1: fl = t_level'(LEVEL_MIN + longint'($urandom_range(0, int'(-LEVEL_MIN))));
            default: fl = t_level'($urandom);
        endcase
        case ($urandom_range(0, 2))
            0: ce = t_level'(LEVEL_MAX);
            1: ce = t_level'(longint'($urandom_range(0, int'(LEVEL_MAX) + 2000)) - 2000);
            default: ce = t_level'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: att = '0;
            1: att = '1;
            default: att = COEFF_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: rel = '0;
            1: rel = '1;
            default: rel = COEFF_W'($urandom);
        endcase
        if ($urandom_range(0, 5) == 0) ticks = TICKS_W'($urandom);
        else ticks = TICKS_W'($urandom_range(0, 40));
        case ($urandom_range(0, 3))
            0: step = '0;
            1: step = '1;
            default: step = STEP_W'($urandom);
        endcase
        load_settings(fl, ce, att, rel, ticks, step, $urandom_range(0, 4) != 0);
    endtask

    // Result side: random stalls, one long hold-off on request, none at the end
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_OFF) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings straight out of reset
        send_tick(t_level'(LEVEL_MAX));
        send_tick(t_level'(LEVEL_MIN));
        send_tick(t_level'(RST_FLOOR_DB));
        send_tick(t_level'(RST_FLOOR_DB - 1));
        send_tick(t_level'(1));
        send_tick(t_level'(-1));
        drain_meter();

        // zero hold time, fastest attack, frozen release, largest fall step
        load_settings(t_level'(RST_FLOOR_DB), t_level'(0), '1, '0, '0, '1, 1'b1);
        send_tick(t_level'(0));
        send_tick(t_level'(LEVEL_MIN));
        send_tick(t_level'(LEVEL_MIN));
        send_tick(t_level'(LEVEL_MIN));
        send_tick(t_level'(-5000));
        drain_meter();

        // floor above ceiling
        load_settings(t_level'(1000), t_level'(-1000), COEFF_W'(32768), COEFF_W'(32768),
                      TICKS_W'(3), STEP_W'(100), 1'b1);
        send_tick(t_level'(0));
        send_tick(t_level'(2000));
        send_tick(t_level'(-2000));
        send_tick(t_level'(500));
        send_tick(t_level'(LEVEL_MIN));
        drain_meter();

        // hold disabled, full range, no attack, instant release
        load_settings(t_level'(LEVEL_MIN), t_level'(LEVEL_MAX), '0, '1, '1, '0, 1'b0);
        send_tick(t_level'(LEVEL_MAX));
        send_tick(t_level'(LEVEL_MIN));
        send_tick(t_level'(12345));
        send_tick(t_level'(-12345));
        drain_meter();

        // one high peak, then a long quiet run past the counter's ceiling
        load_settings(t_level'(LEVEL_MIN), t_level'(LEVEL_MAX), '1, '1, '1, '1, 1'b1);
        send_tick(t_level'(LEVEL_MAX));
        repeat (SAT_TICKS)
            send_tick(t_level'(LEVEL_MIN + longint'($urandom_range(0, int'(LEVEL_MAX)))));
        drain_meter();

        // random settings with peak-and-decay material
        for (int p = 0; p < RAND_PHASES; p++) begin
            load_random_settings();
            if (p == 1) long_hold_req = 1'b1;
            repeat (RAND_TICKS) send_tick(next_level());
            drain_meter();
        end

        // closing run with both sides streaming flat out
        quiet_tail = 1'b1;
        load_random_settings();
        repeat (TAIL_TICKS) send_tick(next_level());
        drain_meter();

        $display("Run: %0d meter ticks over %0d register settings, %0d results compared",
                 ticks_sent, settings_loaded, result_count);
        $display("Included crossed floor and ceiling, hold off, zero hold time, "
                 , "counter saturation and a long output stall");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Run timed out with %0d results outstanding", pending);
        $display("Verification failed");
        $finish;
    end

endmodule
